>>> sv/sprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_pkg: shared types and constants of the slotted page record store
// Operation codes, status codes, defaults, the item structs and the command/status structs.
// ----------------------------------------------------------------------------
package sprs_pkg;

  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int SLOT_BYTES_DEF   = 4;
  localparam int MAX_SLOTS_DEF    = 1024;

  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_COMPACT = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_PAST_LEN = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  record_byte;
    logic [11:0] record_length;
    logic        last_byte;
    logic [9:0]  slot_index;
    logic [11:0] byte_position;
    logic [7:0]  page_type;
    logic [31:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  new_slot;
    logic [7:0]  data_out;
    logic [11:0] slot_length;
    logic [9:0]  count_now;
    logic [12:0] free_now;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch a new item, do its first step
    logic rd_phase;  // read item: final step, page data is valid
    logic cmp_init;  // compact: reset walker
    logic cmp_slot;  // compact: fetch slot entry
    logic cmp_eval;  // compact: evaluate fetched entry
    logic cmp_rd;    // compact: issue byte read
    logic cmp_wr;    // compact: write byte read last cycle
    logic cmp_done;  // compact: commit free offset
    logic finish;    // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slots_done; // walker past live slots
    logic move;       // evaluated entry needs its bytes moved
    logic bytes_done; // last byte of current entry issued
  } dp_sts_t;

endpackage

>>> sv/sprs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_if: valid/ready channel carrying one item
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface sprs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/slotted_page_record_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_record_store: one slotted database page
// Init, byte-wise insert, byte read, slot delete and compaction of a page.
// ----------------------------------------------------------------------------
// Every item gives one result item. Init, insert byte, delete and unknown codes
// finish in the step that accepts them; read fetches the slot entry from the slot
// table, then the byte through the registered page memory read port, then loads
// the result. Compact accepts the item, then walks the live slots through the
// slot table: it fetches and evaluates each entry, copies a moved record byte by
// byte and finishes it, and at the end commits the free offset.
// The page memory and slot table come up undefined; init does not clear them.
// A new item is taken only when the result register is empty or its waiting
// item leaves in the same cycle.
module slotted_page_record_store #(
  parameter int PAGE_BYTES   = sprs_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = sprs_pkg::HEADER_BYTES_DEF,
  parameter int SLOT_BYTES   = sprs_pkg::SLOT_BYTES_DEF,
  parameter int MAX_SLOTS    = sprs_pkg::MAX_SLOTS_DEF
) (
  input logic clk,
  input logic rst_n,
  sprs_if.sink   in_ch,
  sprs_if.source out_ch
);
  import sprs_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;
  in_item_t  in_item;

  // unpack the channel payload
  assign in_item = in_item_t'(in_ch.data);

  sprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_item.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sprs_dp #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .SLOT_BYTES   (SLOT_BYTES),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  // drive the result payload
  assign out_ch.data = res;

  // hold off input while a result waits unconsumed
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !(cmd.start && cmd.finish && !in_ch.ready))
    else $error("item accepted over a stalled result");
  // a result must follow an accepted item that finishes on acceptance
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && cmd.finish) |=> out_ch.valid)
    else $error("result missing after single-cycle item");
  // compact and read never accept new input mid-flight
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmp_rd || cmd.cmp_eval || cmd.rd_phase) |-> !in_ch.ready)
    else $error("input ready while busy");
endmodule

>>> sv/sprs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_ctrl: sequencer of the slotted page record store
// Accepts an item, steps read and compact, hands the result to the output.
// ----------------------------------------------------------------------------
module sprs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sprs_pkg::dp_cmd_t cmd,
  input  sprs_pkg::dp_sts_t sts
);
  import sprs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CSLT = 3'd2;
  localparam logic [2:0] S_CEVL = 3'd3;
  localparam logic [2:0] S_CMOV = 3'd4;
  localparam logic [2:0] S_CLST = 3'd5;
  localparam logic [2:0] S_RDAT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // accept when idle and the result slot is free or being drained
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          if (in_op == OP_READ) begin
            state_nxt = S_READ;
          end else if (in_op == OP_COMPACT) begin
            cmd.cmp_init = 1'b1;
            state_nxt = S_CSLT;
          end else begin
            cmd.finish = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      // slot entry is valid, page byte read is issued
      S_READ: begin
        state_nxt = S_RDAT;
      end
      S_RDAT: begin
        cmd.rd_phase = 1'b1;
        cmd.finish = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CSLT: begin
        if (sts.slots_done) begin
          cmd.cmp_done = 1'b1;
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.cmp_slot = 1'b1;
          state_nxt = S_CEVL;
        end
      end
      S_CEVL: begin
        cmd.cmp_eval = 1'b1;
        state_nxt = sts.move ? S_CMOV : S_CSLT;
      end
      S_CMOV: begin
        cmd.cmp_rd = 1'b1;
        if (sts.bytes_done) state_nxt = S_CLST;
      end
      S_CLST: begin
        cmd.cmp_wr = 1'b1;
        state_nxt = S_CSLT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

>>> sv/sprs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_dp: page memory, slot table and page registers
// Executes one step of an item per command from the sequencer.
// ----------------------------------------------------------------------------
module sprs_dp #(
  parameter int PAGE_BYTES   = sprs_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = sprs_pkg::HEADER_BYTES_DEF,
  parameter int SLOT_BYTES   = sprs_pkg::SLOT_BYTES_DEF,
  parameter int MAX_SLOTS    = sprs_pkg::MAX_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sprs_pkg::in_item_t  in_item,
  input  sprs_pkg::dp_cmd_t   cmd,
  output sprs_pkg::dp_sts_t   sts,
  output sprs_pkg::out_item_t res
);
  import sprs_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);       // page address
  localparam int OW = AW + 1;                   // offset, may equal page size
  localparam int SW = $clog2(MAX_SLOTS);        // slot index
  localparam int CW = SW + 1;                   // slot count
  localparam int NW = OW + CW + 6;              // space check sum

  logic [7:0]    page_mem [PAGE_BYTES];
  logic [OW-1:0] soff_mem [MAX_SLOTS];
  logic [11:0]   slen_mem [MAX_SLOTS];

  logic [CW-1:0] live_r;
  logic [OW-1:0] free_r;
  logic [7:0]    ptype_r;
  logic [31:0]   pnum_r;
  logic          ins_act_r, ins_fail_r;
  logic [OW-1:0] cursor_r;
  logic [11:0]   ins_len_r;

  in_item_t      item_r;
  logic [1:0]    st_r;
  logic [SW-1:0] nslot_r;
  logic          rd_ok_r;   // read/delete item: slot index valid, a read may return a byte
  logic [7:0]    prd_r;
  logic [OW-1:0] soff_q_r;
  logic [11:0]   slen_q_r;

  // compact walker
  logic [CW-1:0] ci_r;
  logic [OW-1:0] cnext_r, csrc_r, cdst_r;
  logic [11:0]   ck_r;
  logic          cwr_pend_r;
  logic [OW-1:0] cwr_addr_r;

  // ---- insert decision on the accepted item ----
  logic          first, fail_now, do_store;
  logic [OW-1:0] base, cur;
  logic [11:0]   len;
  logic [NW-1:0] need;
  logic [OW-1:0] stored;
  always_comb begin
    first = !ins_act_r;
    need  = NW'(free_r) + NW'(in_item.record_length)
          + (NW'(live_r) + NW'(1)) * NW'(SLOT_BYTES);
    fail_now = first ? ((live_r >= CW'(MAX_SLOTS)) || (need > NW'(PAGE_BYTES)))
                     : ins_fail_r;
    cur  = first ? free_r : cursor_r;
    len  = first ? in_item.record_length : ins_len_r;
    base = free_r;
    do_store = !fail_now && ((cur - base) < OW'(len)) && (cur < OW'(PAGE_BYTES));
    stored = do_store ? (cur + OW'(1) - base) : (cur - base);
  end

  logic          idx_ok;
  assign idx_ok = CW'(in_item.slot_index) < live_r;

  assign sts.slots_done = ci_r >= live_r;
  assign sts.move       = (slen_q_r != 12'd0) && (soff_q_r != cnext_r);
  assign sts.bytes_done = (ck_r + 12'd1) >= slen_q_r;

  logic [OW-1:0] rd_addr;
  assign rd_addr = soff_q_r + OW'(item_r.byte_position);

  always_ff @(posedge clk) begin
    // page memory: one write port, one registered read port
    if (cmd.start && in_item.operation == OP_INSERT && do_store)
      page_mem[cur[AW-1:0]] <= in_item.record_byte;
    else if (cwr_pend_r)
      page_mem[cwr_addr_r[AW-1:0]] <= prd_r;
    if (cmd.cmp_rd) prd_r <= page_mem[csrc_r[AW-1:0]];
    else            prd_r <= page_mem[rd_addr[AW-1:0]];

    // slot table: registered read at walker or item index
    if (cmd.start) begin
      soff_q_r <= soff_mem[in_item.slot_index[SW-1:0]];
      slen_q_r <= slen_mem[in_item.slot_index[SW-1:0]];
    end else if (cmd.cmp_slot) begin
      soff_q_r <= soff_mem[ci_r[SW-1:0]];
      slen_q_r <= slen_mem[ci_r[SW-1:0]];
    end
    if (cmd.start && in_item.operation == OP_INSERT && in_item.last_byte && !fail_now) begin
      soff_mem[live_r[SW-1:0]] <= base;
      slen_mem[live_r[SW-1:0]] <= stored[11:0];
    end else if (cmd.start && in_item.operation == OP_DELETE && idx_ok) begin
      slen_mem[in_item.slot_index[SW-1:0]] <= 12'd0;
    end else if (cmd.cmp_eval && slen_q_r != 12'd0) begin
      soff_mem[ci_r[SW-1:0] - SW'(1)] <= cnext_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r     <= '0;
      free_r     <= OW'(HEADER_BYTES);
      ptype_r    <= '0;
      pnum_r     <= '0;
      ins_act_r  <= 1'b0;
      ins_fail_r <= 1'b0;
      cursor_r   <= '0;
      ins_len_r  <= '0;
      cwr_pend_r <= 1'b0;
    end else begin
      cwr_pend_r <= cmd.cmp_rd;
      cwr_addr_r <= cdst_r;
      if (cmd.start) begin
        item_r <= in_item;
        st_r <= ST_OK;
        nslot_r <= '0;
        rd_ok_r <= 1'b0;
        if (in_item.operation != OP_INSERT) begin
          ins_act_r  <= 1'b0;
          ins_fail_r <= 1'b0;
        end
        unique case (in_item.operation)
          OP_INIT: begin
            ptype_r <= in_item.page_type;
            pnum_r  <= in_item.page_number;
            live_r  <= '0;
            free_r  <= OW'(HEADER_BYTES);
          end
          OP_INSERT: begin
            st_r <= fail_now ? ST_NO_SPACE : ST_OK;
            if (in_item.last_byte) begin
              ins_act_r  <= 1'b0;
              ins_fail_r <= 1'b0;
              if (!fail_now) begin
                nslot_r <= live_r[SW-1:0];
                live_r  <= live_r + CW'(1);
                free_r  <= base + stored;
              end
            end else begin
              ins_act_r  <= 1'b1;
              ins_fail_r <= fail_now;
              cursor_r   <= do_store ? cur + OW'(1) : cur;
              ins_len_r  <= len;
            end
          end
          OP_READ, OP_DELETE: begin
            if (!idx_ok) st_r <= ST_BAD_SLOT;
            else rd_ok_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.cmp_init) begin
        ci_r <= '0;
        cnext_r <= OW'(HEADER_BYTES);
      end
      if (cmd.cmp_slot) ci_r <= ci_r + CW'(1);
      if (cmd.cmp_eval) begin
        ck_r <= '0;
        csrc_r <= soff_q_r;
        cdst_r <= cnext_r;
        cnext_r <= cnext_r + OW'(slen_q_r);
      end
      if (cmd.cmp_rd) begin
        ck_r <= ck_r + 12'd1;
        csrc_r <= csrc_r + OW'(1);
        cdst_r <= cdst_r + OW'(1);
      end
      if (cmd.cmp_done) free_r <= cnext_r;
    end
  end

  // ---- result register ----
  // read: status and byte are settled in the final step from the slot entry
  // and the registered page byte
  logic          rd_now;
  logic [1:0]    fin_st;
  logic [7:0]    fin_data;
  logic [11:0]   fin_len;
  assign rd_now = cmd.rd_phase && rd_ok_r;
  always_comb begin
    fin_st = cmd.start ? ST_OK : st_r;
    fin_data = '0;
    fin_len  = '0;
    if (rd_now) begin
      fin_len = slen_q_r;
      if (item_r.byte_position >= slen_q_r) fin_st = ST_PAST_LEN;
      else if (rd_addr < OW'(PAGE_BYTES)) fin_data = prd_r;
    end
  end
  // insert/init/delete and unknown-code results are set on acceptance from the item and page state
  logic [1:0] st_direct;
  always_comb begin
    st_direct = ST_OK;
    if (in_item.operation == OP_INSERT && fail_now) st_direct = ST_NO_SPACE;
    if (in_item.operation == OP_DELETE && !idx_ok) st_direct = ST_BAD_SLOT;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.start) begin
        res.status   <= st_direct;
        res.new_slot <= (in_item.operation == OP_INSERT && in_item.last_byte && !fail_now)
                        ? 10'(live_r) : 10'd0;
        res.data_out <= '0;
        res.slot_length <= '0;
        unique case (in_item.operation)
          OP_INIT: begin
            res.count_now <= '0;
            res.free_now  <= 13'(HEADER_BYTES);
          end
          OP_INSERT: begin
            res.count_now <= (in_item.last_byte && !fail_now) ? 10'(live_r + CW'(1))
                                                             : 10'(live_r);
            res.free_now  <= (in_item.last_byte && !fail_now) ? 13'(base + stored)
                                                             : 13'(free_r);
          end
          default: begin
            res.count_now <= 10'(live_r);
            res.free_now  <= 13'(free_r);
          end
        endcase
      end else begin
        res.status      <= fin_st;
        res.new_slot    <= '0;
        res.data_out    <= fin_data;
        res.slot_length <= fin_len;
        res.count_now   <= 10'(live_r);
        res.free_now    <= cmd.cmp_done ? 13'(cnext_r) : 13'(free_r);
      end
    end
  end

  // page identity is held for a future header view
  logic unused_id;
  assign unused_id = ^{ptype_r, pnum_r, nslot_r};
endmodule
